### src/bpa_pkg.sv
package bpa_pkg;

    // Command codes of a request
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_ALLOC  = 3'd1;
    localparam logic [2:0] CMD_FREE   = 3'd2;
    localparam logic [2:0] CMD_RETAIN = 3'd3;
    localparam logic [2:0] CMD_QUERY  = 3'd4;

    localparam logic [3:0]  NOT_HEAD = 4'hF;
    localparam logic [15:0] REF_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFREE  = 3'd1,
        ST_BADORD  = 3'd2,
        ST_IGNORED = 3'd3,
        ST_DROPPED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_FREE  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_RES   = 2'd2
    } kind_t;

    // One page descriptor word
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  hord;
        logic [15:0] refc;
    } pword_t;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_IDLE    = 5'd0,
        OP_DEC     = 5'd1,
        OP_SWEEP   = 5'd2,
        OP_CARVE   = 5'd3,
        OP_PUSHA   = 5'd4,
        OP_PUSHB   = 5'd5,
        OP_SRCH    = 5'd6,
        OP_SPLSEL  = 5'd7,
        OP_UNLA    = 5'd8,
        OP_UNLB    = 5'd9,
        OP_SPLHALF = 5'd10,
        OP_MARK    = 5'd11,
        OP_PGCHK   = 5'd12,
        OP_MRG0    = 5'd13,
        OP_MRG1    = 5'd14,
        OP_MRGUP   = 5'd15,
        OP_FIN     = 5'd16
    } op_t;

    typedef struct packed {
        op_t     op;
        logic    st_we;
        status_t st;
    } ctl_t;

    typedef struct packed {
        logic is_init;
        logic is_alloc;
        logic is_page;
        logic page_in;
        logic order_bad;
        logic head_empty;
        logic f_last;
        logic f_gt;
        logic carve_more;
        logic sweep_last;
        logic mark_last;
        logic need_merge;
        logic merge_stop;
        logic merge_ok;
        logic out_free;
    } dp_stat_t;

endpackage

### src/bpa_req_if.sv
interface bpa_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [3:0] order;
    logic [11:0] page;

    modport source (output valid, cmd, order, page, input ready);
    modport sink   (input valid, cmd, order, page, output ready);
endinterface

### src/bpa_rsp_if.sv
interface bpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [9:0]  block_page;
    logic [15:0] ref_count;
    logic [10:0] free_pages;

    modport source (output valid, status, block_page, ref_count, free_pages, input ready);
    modport sink   (input valid, status, block_page, ref_count, free_pages, output ready);
endinterface

### src/bpa_ctrl.sv
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output ctl_t     ctl
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'b00000000000000001,
        S_DEC     = 17'b00000000000000010,
        S_SWEEP   = 17'b00000000000000100,
        S_CARVE   = 17'b00000000000001000,
        S_PUSHA   = 17'b00000000000010000,
        S_PUSHB   = 17'b00000000000100000,
        S_SRCH    = 17'b00000000001000000,
        S_SPLIT   = 17'b00000000010000000,
        S_UNLA    = 17'b00000000100000000,
        S_UNLB    = 17'b00000001000000000,
        S_SPLHALF = 17'b00000010000000000,
        S_MARK    = 17'b00000100000000000,
        S_PGCHK   = 17'b00001000000000000,
        S_MRG0    = 17'b00010000000000000,
        S_MRG1    = 17'b00100000000000000,
        S_MRGUP   = 17'b01000000000000000,
        S_FIN     = 17'b10000000000000000
    } state_t;

    // Which sequence a shared push or unlink returns to
    typedef enum logic [2:0] {
        CX_RESET = 3'd0,
        CX_INIT  = 3'd1,
        CX_SPLIT = 3'd2,
        CX_FINAL = 3'd3,
        CX_MERGE = 3'd4
    } ctx_t;

    state_t state_reg, state_next;
    ctx_t   ctx_reg, ctx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            ctx_reg   <= CX_RESET;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and micro-op
    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        ctl.op     = OP_IDLE;
        ctl.st_we  = 1'b0;
        ctl.st     = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                ctl.op = OP_IDLE;
                if (in_valid)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                ctl.op = OP_DEC;
                if (stat.is_init)
                begin
                    ctx_next   = CX_INIT;
                    state_next = S_SWEEP;
                end
                else if (stat.is_alloc)
                begin
                    if (stat.order_bad)
                    begin
                        ctl.st_we  = 1'b1;
                        ctl.st     = ST_BADORD;
                        state_next = S_FIN;
                    end
                    else
                        state_next = S_SRCH;
                end
                else if (stat.is_page && stat.page_in)
                    state_next = S_PGCHK;
                else
                    state_next = S_FIN;
            end
            S_SWEEP:
            begin
                ctl.op = OP_SWEEP;
                if (stat.sweep_last)
                    state_next = (ctx_reg == CX_RESET) ? S_IDLE : S_CARVE;
            end
            S_CARVE:
            begin
                ctl.op = OP_CARVE;
                if (!stat.carve_more)
                begin
                    ctl.st_we  = 1'b1;
                    ctl.st     = ST_OK;
                    state_next = S_FIN;
                end
                else
                    state_next = S_PUSHA;
            end
            S_PUSHA:
            begin
                ctl.op     = OP_PUSHA;
                state_next = S_PUSHB;
            end
            S_PUSHB:
            begin
                ctl.op = OP_PUSHB;
                case (ctx_reg)
                    CX_INIT:  state_next = S_CARVE;
                    CX_SPLIT: state_next = S_SPLIT;
                    default:  state_next = S_FIN;
                endcase
            end
            S_SRCH:
            begin
                ctl.op = OP_SRCH;
                if (!stat.head_empty)
                    state_next = S_SPLIT;
                else if (stat.f_last)
                begin
                    ctl.st_we  = 1'b1;
                    ctl.st     = ST_NOFREE;
                    state_next = S_FIN;
                end
            end
            S_SPLIT:
            begin
                ctl.op     = OP_SPLSEL;
                ctx_next   = stat.f_gt ? CX_SPLIT : CX_FINAL;
                state_next = S_UNLA;
            end
            S_UNLA:
            begin
                ctl.op     = OP_UNLA;
                state_next = S_UNLB;
            end
            S_UNLB:
            begin
                ctl.op = OP_UNLB;
                case (ctx_reg)
                    CX_SPLIT: state_next = S_SPLHALF;
                    CX_FINAL: state_next = S_MARK;
                    default:  state_next = S_MRGUP;
                endcase
            end
            S_SPLHALF:
            begin
                ctl.op     = OP_SPLHALF;
                state_next = S_PUSHA;
            end
            S_MARK:
            begin
                ctl.op = OP_MARK;
                if (stat.mark_last)
                begin
                    ctl.st_we  = 1'b1;
                    ctl.st     = ST_OK;
                    state_next = S_FIN;
                end
            end
            S_PGCHK:
            begin
                ctl.op     = OP_PGCHK;
                state_next = stat.need_merge ? S_MRG0 : S_FIN;
            end
            S_MRG0:
            begin
                ctl.op     = OP_MRG0;
                ctx_next   = CX_MERGE;
                state_next = stat.merge_stop ? S_PUSHA : S_MRG1;
            end
            S_MRG1:
            begin
                ctl.op     = OP_MRG1;
                state_next = stat.merge_ok ? S_UNLA : S_PUSHA;
            end
            S_MRGUP:
            begin
                ctl.op     = OP_MRGUP;
                state_next = S_MRG0;
            end
            S_FIN:
            begin
                ctl.op = OP_FIN;
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // An accepted request is decoded in the next cycle
    a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> state_reg == S_DEC)
        else $error("accepted request not decoded");

    // Power-up clearing returns to idle
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP && ctx_reg == CX_RESET && stat.sweep_last)
        |=> state_reg == S_IDLE)
        else $error("clearing pass did not end in idle");

    // Final push of a merge closes the request
    a_merge_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSHB && ctx_reg == CX_MERGE) |=> state_reg == S_FIN)
        else $error("merge push did not finish");

endmodule

### src/bpa_dp.sv
module bpa_dp
    import bpa_pkg::*;
#(
    parameter int PAGE_COUNT  = 1024,
    parameter int ORDER_COUNT = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    output dp_stat_t    stat,
    input  logic        take,
    input  logic [2:0]  in_cmd,
    input  logic [3:0]  in_order,
    input  logic [11:0] in_page,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_status,
    output logic [9:0]  out_block,
    output logic [15:0] out_refs,
    output logic [10:0] out_free
);

    localparam int AW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int PW = $clog2(PAGE_COUNT + 1);
    localparam int LW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
    localparam logic [PW-1:0] NIL = PW'(PAGE_COUNT);

    // Page descriptors and free-list links
    pword_t        pmem       [PAGE_COUNT];
    logic [PW-1:0] lnext_mem  [PAGE_COUNT];
    logic [PW-1:0] lprev_mem  [PAGE_COUNT];
    pword_t        pm_rd_reg;
    logic [PW-1:0] rd_n_reg, rd_v_reg;

    logic          pm_we;
    logic [AW-1:0] pm_waddr, pm_raddr;
    pword_t        pm_wdata;
    logic          ln_we, lp_we;
    logic [AW-1:0] ln_waddr, lp_waddr;
    logic [PW-1:0] ln_wdata, lp_wdata;

    logic [10:0]   cfg_res_reg, cfg_res_next;
    logic [PW-1:0] rsat_reg, rsat_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] total_reg, total_next;
    logic [PW-1:0] lhead_reg [ORDER_COUNT];
    logic [PW-1:0] lhead_next [ORDER_COUNT];
    logic          out_valid_reg, out_valid_next;

    logic [2:0]    cmd_reg, cmd_next;
    logic [3:0]    ord_reg, ord_next;
    logic [11:0]   page_reg, page_next;
    logic [3:0]    f_reg, f_next;
    logic [PW-1:0] up_reg, up_next;
    logic [3:0]    uo_reg, uo_next;
    logic [PW-1:0] pp_reg, pp_next;
    logic [3:0]    po_reg, po_next;
    logic [PW-1:0] mp_reg, mp_next;
    logic [3:0]    mo_reg, mo_next;
    status_t       res_st_reg, res_st_next;
    logic [PW-1:0] res_blk_reg, res_blk_next;
    logic [15:0]   res_ref_reg, res_ref_next;
    status_t       out_st_reg, out_st_next;
    logic [PW-1:0] out_blk_reg, out_blk_next;
    logic [15:0]   out_ref_reg, out_ref_next;
    logic [PW-1:0] out_free_reg, out_free_next;

    logic [31:0]   pow_po, pow_uo, b32, pp32, span, rsat32;
    logic [3:0]    carve_ord, fm1;
    logic          carve_go;
    logic [PW-1:0] h, head_f;
    logic          is_alloc_pg;

    // Memories
    always_ff @(posedge clk)
    begin
        if (pm_we)
            pmem[pm_waddr] <= pm_wdata;
        pm_rd_reg <= pmem[pm_raddr];
        if (ln_we)
            lnext_mem[ln_waddr] <= ln_wdata;
        if (lp_we)
            lprev_mem[lp_waddr] <= lp_wdata;
        rd_n_reg <= lnext_mem[AW'(up_reg)];
        rd_v_reg <= lprev_mem[AW'(up_reg)];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_res_reg   <= '0;
            rsat_reg      <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ORDER_COUNT; i++)
                lhead_reg[i] <= NIL;
        end
        else
        begin
            cfg_res_reg   <= cfg_res_next;
            rsat_reg      <= rsat_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < ORDER_COUNT; i++)
                lhead_reg[i] <= lhead_next[i];
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        ord_reg      <= ord_next;
        page_reg     <= page_next;
        f_reg        <= f_next;
        up_reg       <= up_next;
        uo_reg       <= uo_next;
        pp_reg       <= pp_next;
        po_reg       <= po_next;
        mp_reg       <= mp_next;
        mo_reg       <= mo_next;
        res_st_reg   <= res_st_next;
        res_blk_reg  <= res_blk_next;
        res_ref_reg  <= res_ref_next;
        out_st_reg   <= out_st_next;
        out_blk_reg  <= out_blk_next;
        out_ref_reg  <= out_ref_next;
        out_free_reg <= out_free_next;
    end

    // Shared terms
    assign pow_po      = 32'd1 << po_reg;
    assign pow_uo      = 32'd1 << uo_reg;
    assign b32         = 32'(mp_reg) ^ (32'd1 << mo_reg);
    assign fm1         = f_reg - 4'd1;
    assign h           = lhead_reg[LW'(po_reg)];
    assign head_f      = lhead_reg[LW'(f_reg)];
    assign rsat32      = (32'(cfg_res_reg) > 32'(PAGE_COUNT)) ? 32'(PAGE_COUNT)
                                                              : 32'(cfg_res_reg);
    assign is_alloc_pg = (pm_rd_reg.kind == KIND_ALLOC);

    // Largest aligned block that fits at the carve pointer
    always_comb
    begin
        pp32      = 32'(pp_reg);
        carve_ord = '0;
        carve_go  = 1'b1;
        span      = 32'd1;
        for (int k = 1; k < ORDER_COUNT; k++)
        begin
            span = 32'd1 << k;
            if (carve_go && ((pp32 & (span - 32'd1)) == 32'd0)
                && (pp32 + span <= 32'(PAGE_COUNT)))
                carve_ord = 4'(k);
            else
                carve_go = 1'b0;
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat.is_init    = (cmd_reg == CMD_INIT);
        stat.is_alloc   = (cmd_reg == CMD_ALLOC);
        stat.is_page    = (cmd_reg inside {CMD_FREE, CMD_RETAIN, CMD_QUERY});
        stat.page_in    = (32'(page_reg) < 32'(PAGE_COUNT));
        stat.order_bad  = (32'(ord_reg) >= 32'(ORDER_COUNT));
        stat.head_empty = (head_f >= NIL);
        stat.f_last     = (32'(f_reg) == 32'(ORDER_COUNT - 1));
        stat.f_gt       = (f_reg > ord_reg);
        stat.carve_more = (pp_reg < NIL);
        stat.sweep_last = (cnt_reg == PW'(PAGE_COUNT - 1));
        stat.mark_last  = (cnt_reg == PW'(pow_uo - 32'd1));
        stat.need_merge = (cmd_reg == CMD_FREE) && is_alloc_pg
                          && (pm_rd_reg.refc <= 16'd1);
        stat.merge_stop = (32'(mo_reg) + 32'd1 >= 32'(ORDER_COUNT))
                          || (b32 >= 32'(PAGE_COUNT));
        stat.merge_ok   = (pm_rd_reg.kind == KIND_FREE) && (pm_rd_reg.hord == mo_reg)
                          && (pm_rd_reg.refc == 16'd0);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Micro-operation decode
    always_comb
    begin
        cfg_res_next   = cfg_we ? cfg_wdata : cfg_res_reg;
        rsat_next      = rsat_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        for (int i = 0; i < ORDER_COUNT; i++)
            lhead_next[i] = lhead_reg[i];
        cmd_next       = cmd_reg;
        ord_next       = ord_reg;
        page_next      = page_reg;
        f_next         = f_reg;
        up_next        = up_reg;
        uo_next        = uo_reg;
        pp_next        = pp_reg;
        po_next        = po_reg;
        mp_next        = mp_reg;
        mo_next        = mo_reg;
        res_st_next    = ctl.st_we ? ctl.st : res_st_reg;
        res_blk_next   = res_blk_reg;
        res_ref_next   = res_ref_reg;
        out_st_next    = out_st_reg;
        out_blk_next   = out_blk_reg;
        out_ref_next   = out_ref_reg;
        out_free_next  = out_free_reg;
        pm_we          = 1'b0;
        pm_waddr       = AW'(pp_reg);
        pm_wdata       = '{kind: KIND_FREE, hord: NOT_HEAD, refc: 16'd0};
        pm_raddr       = AW'(page_reg);
        ln_we          = 1'b0;
        ln_waddr       = AW'(pp_reg);
        ln_wdata       = h;
        lp_we          = 1'b0;
        lp_waddr       = AW'(pp_reg);
        lp_wdata       = NIL;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (ctl.op)
            OP_IDLE:
            begin
                if (take)
                begin
                    cmd_next  = in_cmd;
                    ord_next  = in_order;
                    page_next = in_page;
                end
            end
            OP_DEC:
            begin
                rsat_next    = PW'(rsat32);
                pp_next      = PW'(rsat32);
                cnt_next     = '0;
                f_next       = ord_reg;
                res_blk_next = '0;
                res_ref_next = '0;
                if (!ctl.st_we)
                    res_st_next = ST_IGNORED;
            end
            OP_SWEEP:
            begin
                pm_we         = 1'b1;
                pm_waddr      = AW'(cnt_reg);
                pm_wdata.kind = (cnt_reg < rsat_reg) ? KIND_RES : KIND_FREE;
                cnt_next      = cnt_reg + PW'(1);
                if (cnt_reg == '0)
                begin
                    total_next = '0;
                    for (int i = 0; i < ORDER_COUNT; i++)
                        lhead_next[i] = NIL;
                end
            end
            OP_CARVE:
            begin
                po_next = carve_ord;
            end
            // Push block pp of order po onto the head of its list
            OP_PUSHA:
            begin
                pm_we         = 1'b1;
                pm_waddr      = AW'(pp_reg);
                pm_wdata.hord = po_reg;
                ln_we         = 1'b1;
                ln_waddr      = AW'(pp_reg);
                ln_wdata      = h;
                if (h < NIL)
                begin
                    lp_we    = 1'b1;
                    lp_waddr = AW'(h);
                    lp_wdata = pp_reg;
                end
                lhead_next[LW'(po_reg)] = pp_reg;
                total_next = total_reg + PW'(pow_po);
            end
            OP_PUSHB:
            begin
                lp_we    = 1'b1;
                lp_waddr = AW'(pp_reg);
                lp_wdata = NIL;
                pp_next  = pp_reg + PW'(pow_po);
            end
            OP_SRCH:
            begin
                if (stat.head_empty && !stat.f_last)
                    f_next = f_reg + 4'd1;
            end
            OP_SPLSEL:
            begin
                up_next  = head_f;
                uo_next  = f_reg;
                cnt_next = '0;
            end
            OP_UNLA:
            begin
                // link read of up is under way
            end
            // Unlink block up of order uo
            OP_UNLB:
            begin
                if (rd_v_reg < NIL)
                begin
                    ln_we    = 1'b1;
                    ln_waddr = AW'(rd_v_reg);
                    ln_wdata = rd_n_reg;
                end
                else
                    lhead_next[LW'(uo_reg)] = rd_n_reg;
                if (rd_n_reg < NIL)
                begin
                    lp_we    = 1'b1;
                    lp_waddr = AW'(rd_n_reg);
                    lp_wdata = rd_v_reg;
                end
                pm_we      = 1'b1;
                pm_waddr   = AW'(up_reg);
                total_next = total_reg - PW'(pow_uo);
            end
            OP_SPLHALF:
            begin
                f_next  = fm1;
                pp_next = up_reg + PW'(32'd1 << fm1);
                po_next = fm1;
            end
            OP_MARK:
            begin
                pm_we        = 1'b1;
                pm_waddr     = AW'(up_reg + cnt_reg);
                pm_wdata     = '{kind: KIND_ALLOC, hord: NOT_HEAD, refc: 16'd1};
                cnt_next     = cnt_reg + PW'(1);
                res_blk_next = up_reg;
                res_ref_next = 16'd1;
            end
            OP_PGCHK:
            begin
                pm_waddr     = AW'(page_reg);
                pm_wdata     = pm_rd_reg;
                res_ref_next = pm_rd_reg.refc;
                res_st_next  = ST_OK;
                mp_next      = PW'(page_reg);
                mo_next      = 4'd0;
                case (cmd_reg)
                    CMD_RETAIN:
                    begin
                        if (!is_alloc_pg)
                            res_st_next = ST_IGNORED;
                        else if (pm_rd_reg.refc != REF_MAX)
                        begin
                            pm_we         = 1'b1;
                            pm_wdata.refc = pm_rd_reg.refc + 16'd1;
                            res_ref_next  = pm_rd_reg.refc + 16'd1;
                        end
                    end
                    CMD_FREE:
                    begin
                        pm_we = is_alloc_pg;
                        if (!is_alloc_pg)
                            res_st_next = ST_IGNORED;
                        else if (pm_rd_reg.refc > 16'd1)
                        begin
                            pm_wdata.refc = pm_rd_reg.refc - 16'd1;
                            res_ref_next  = pm_rd_reg.refc - 16'd1;
                            res_st_next   = ST_DROPPED;
                        end
                        else
                        begin
                            pm_wdata.kind = KIND_FREE;
                            pm_wdata.refc = 16'd0;
                            res_ref_next  = 16'd0;
                        end
                    end
                    default:
                    begin
                        res_st_next = ST_OK;
                    end
                endcase
            end
            OP_MRG0:
            begin
                pm_raddr = AW'(b32);
                pp_next  = mp_reg;
                po_next  = mo_reg;
            end
            OP_MRG1:
            begin
                up_next = PW'(b32);
                uo_next = mo_reg;
            end
            OP_MRGUP:
            begin
                mp_next = (up_reg < mp_reg) ? up_reg : mp_reg;
                mo_next = mo_reg + 4'd1;
            end
            OP_FIN:
            begin
                if (stat.out_free)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_blk_next   = res_blk_reg;
                    out_ref_next   = res_ref_reg;
                    out_free_next  = total_reg;
                end
            end
            default:
            begin
                pm_we = 1'b0;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_st_reg;
    assign out_block  = 10'(out_blk_reg);
    assign out_refs   = out_ref_reg;
    assign out_free   = 11'(out_free_reg);

    // Free page total never exceeds the page count
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= NIL)
        else $error("free page total out of range");

    // A block being unlinked sits on a non-empty list
    a_unlink_list: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_UNLB) |-> (lhead_reg[LW'(uo_reg)] < NIL))
        else $error("unlink from an empty list");

    // Finishing with a free output slot presents a result
    a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_FIN && stat.out_free) |=> out_valid_reg)
        else $error("result not presented");

endmodule

### src/buddy_page_allocator_top.sv
// Buddy page allocator with per-page reference counts.
// request channel: cmd, order, page; one result per request on the
// result channel: status, block_page, ref_count, free_pages.
// cfg_we/cfg_wdata write the reserved page count; write it while idle.
// One request is processed at a time. An allocate searches the orders
// upward from the requested one, splits the block it finds down to the
// requested order and marks its pages; a free of the last reference
// merges the block with its free buddies level by level; init clears
// the page descriptors and carves the non-reserved pages into blocks.
// The page descriptor memory (one read and one write port) and the link
// memories are touched one entry per port per cycle. After reset a
// clearing pass over all PAGE_COUNT page descriptors initializes them;
// request.ready stays low until it completes.
// The result sits in an output register; the next request is accepted
// while it waits, and a stalled result only delays the next result.
module buddy_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int PAGE_COUNT  = 1024,
    parameter int ORDER_COUNT = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    bpa_req_if.sink     request,
    bpa_rsp_if.source   result,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata
);

    ctl_t     ctl;
    dp_stat_t stat;
    logic     take;

    assign take = request.valid && request.ready;

    // Sequencer
    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Memories, lists and result register
    bpa_dp #(
        .PAGE_COUNT  (PAGE_COUNT),
        .ORDER_COUNT (ORDER_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .take       (take),
        .in_cmd     (request.cmd),
        .in_order   (request.order),
        .in_page    (request.page),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_status (result.status),
        .out_block  (result.block_page),
        .out_refs   (result.ref_count),
        .out_free   (result.free_pages)
    );

endmodule
